// File: rtl/crc8_frame_checker_unit_assert.svh
// assertion macros used by the frame accumulator module
`ifndef CRC8_FRAME_CHECKER_UNIT_ASSERT_SVH
`define CRC8_FRAME_CHECKER_UNIT_ASSERT_SVH

// condition must hold at every clock edge out of reset
`define CRC8FC_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// consequence must hold in the cycle after the antecedent
`define CRC8FC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/crc8fc_pkg.sv
package crc8fc_pkg;

    localparam logic [7:0] CRC_POLY = 8'h07;
    localparam logic [7:0] CRC_INIT = 8'hFF;
    localparam int         BYTE_W   = 8;
    localparam int         OUT_W    = 16;

    // one frame verdict
    typedef struct packed {
        logic [7:0] crc_residue;
        logic       crc_ok;
        logic       start_ok;
        logic       frame_ok;
    } result_t;

    // msb-first crc-8 over one byte, eight shift steps unrolled
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < BYTE_W; i++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// File: rtl/crc8fc_in_stage.sv
module crc8fc_in_stage (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  logic       take,
    output logic       in_valid,
    output logic [7:0] in_data
);
    import crc8fc_pkg::*;

    logic       in_valid_reg;
    logic [7:0] in_data_reg;

    // accept a new request when empty or when the held byte moves on this cycle
    assign s_axis_tready = !in_valid_reg || take;

    // valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    // byte register
    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_data_reg <= s_axis_tdata[BYTE_W-1:0];
        end
    end

    assign in_valid = in_valid_reg;
    assign in_data  = in_data_reg;

endmodule

// File: rtl/crc8fc_frame_acc.sv
module crc8fc_frame_acc #(
    parameter int FRAME_BYTES = 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [7:0]          cfg_wr_data,
    input  logic                in_valid,
    input  logic [7:0]          in_data,
    input  logic                load_ok,
    output logic                take,
    output logic                res_load,
    output crc8fc_pkg::result_t res
);
    import crc8fc_pkg::*;
    `include "crc8_frame_checker_unit_assert.svh"

    localparam int POS_W = $clog2(FRAME_BYTES);
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 1);

    logic [7:0]       lead_byte_reg;
    logic [7:0]       crc_reg;
    logic [7:0]       crc_next;
    logic [POS_W-1:0] pos_reg;
    logic             start_match_reg;
    logic             start_match_next;
    logic             is_last;
    logic             is_lead;
    logic             at_restart;
    logic             mid_take;

    // start byte register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lead_byte_reg <= 8'h00;
        end else if (cfg_wr_en) begin
            lead_byte_reg <= cfg_wr_data;
        end
    end

    // byte position decode and crc step
    assign is_last  = (pos_reg == LAST_POS);
    assign is_lead  = (pos_reg[POS_W-1:1] == '0);
    assign crc_next = crc8_update(crc_reg, in_data);
    assign start_match_next = start_match_reg && !(is_lead && (in_data != lead_byte_reg));

    // the last byte waits until the result register is free
    assign take     = in_valid && (!is_last || load_ok);
    assign res_load = take && is_last;

    // frame verdict
    always_comb begin
        res.crc_residue = crc_next;
        res.crc_ok      = (crc_next == 8'h00);
        res.start_ok    = start_match_next;
        res.frame_ok    = start_match_next && (crc_next == 8'h00);
    end

    // running frame state, restarted after the last byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg         <= CRC_INIT;
            pos_reg         <= '0;
            start_match_reg <= 1'b1;
        end else if (take) begin
            if (is_last) begin
                crc_reg         <= CRC_INIT;
                pos_reg         <= '0;
                start_match_reg <= 1'b1;
            end else begin
                crc_reg         <= crc_next;
                pos_reg         <= pos_reg + 1'b1;
                start_match_reg <= start_match_next;
            end
        end
    end

    // terms for the checks
    assign at_restart = (pos_reg == '0) && (crc_reg == CRC_INIT) && start_match_reg;
    assign mid_take   = take && !is_lead && !is_last;

    // checks
    `CRC8FC_ASSERT_NEXT(a_restart, res_load, at_restart, "frame state not restarted")
    `CRC8FC_ASSERT_ALWAYS(a_pos_range, pos_reg <= LAST_POS, "byte position beyond frame length")
    `CRC8FC_ASSERT_NEXT(a_match_hold, mid_take, $stable(start_match_reg), "late start match change")

endmodule

// File: rtl/crc8fc_out_stage.sv
module crc8fc_out_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                res_load,
    input  crc8fc_pkg::result_t res,
    output logic                load_ok,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [15:0]         m_axis_tdata   // [0] frame_ok, [1] start_ok, [2] crc_ok,
                                                // [10:3] crc_residue, [15:11] zero
);
    import crc8fc_pkg::*;

    logic          m_valid_reg;
    result_t       m_res_reg;

    // free when empty or when the held result goes out this cycle
    assign load_ok = !m_valid_reg || m_axis_tready;

    // result valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_ok) begin
            m_valid_reg <= res_load;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (load_ok && res_load) begin
            m_res_reg <= res;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = OUT_W'(m_res_reg);

endmodule

// File: rtl/crc8_frame_checker_unit.sv
// Fixed-length frame checker: bytes arriving on the s_axis stream are grouped into frames of
// FRAME_BYTES bytes counted from reset (no resync), an MSB-first CRC-8 (poly 0x07, init 0xFF,
// no reflection, no final xor) runs over each whole frame including its check byte, and the
// first two bytes must equal lead_byte, written through cfg_wr_en/cfg_wr_data. On the last
// byte of a frame one result leaves on m_axis; other bytes produce nothing. The block takes
// one byte per cycle while the last byte of a frame is not held up by a waiting result;
// m_axis_tvalid is set by the result register, loaded through the combinational crc update.
// The last byte of a frame is held in the input register while an earlier result still waits.
module crc8_frame_checker_unit #(
    parameter int FRAME_BYTES = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,    // [7:0] lead_byte
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // [0] frame_ok, [1] start_ok, [2] crc_ok,
                                        // [10:3] crc_residue, [15:11] zero
);
    import crc8fc_pkg::*;

    logic       in_valid;
    logic [7:0] in_data;
    logic       take;
    logic       load_ok;
    logic       res_load;
    result_t    res;

    // input byte register
    crc8fc_in_stage u_in (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .take          (take),
        .in_valid      (in_valid),
        .in_data       (in_data)
    );

    // crc and start byte tracking
    crc8fc_frame_acc #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_acc (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_data     (in_data),
        .load_ok     (load_ok),
        .take        (take),
        .res_load    (res_load),
        .res         (res)
    );

    // result register
    crc8fc_out_stage u_out (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .res_load      (res_load),
        .res           (res),
        .load_ok       (load_ok),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule
